### sv/sts_pkg.sv
// Shared types and constants for the sorted table search unit.
// No dependencies; every other file imports this package.
package sts_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 7;
    localparam int COUNT_W   = 8;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_LINEAR = 2'd1;
    localparam logic [1:0] ACT_BINARY = 2'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } sts_in_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } sts_out_t;

endpackage

### sv/sts_mem.sv
// Table storage: one write port, one read port with registered read data.
// Depends on sts_pkg for the entry width.
module sts_mem
    import sts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/sts_seq.sv
// Search sequencer: bound registers, one shared signed comparator, result register.
// Depends on sts_pkg; drives the read and write ports of sts_mem.
module sts_seq
    import sts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [CW-1:0]            active_count,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  sts_in_t                  s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output sts_out_t                 m_item,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic signed [DATA_W-1:0] wr_data,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  logic signed [DATA_W-1:0] rd_data
);

    localparam int BW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [BW-1:0]     low_reg, low_next;
    logic signed [BW-1:0]     high_reg, high_next;
    logic signed [BW-1:0]     probe_reg, probe_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     binary_reg, binary_next;
    sts_out_t                 result_reg, result_next;
    logic                     m_valid_reg, m_valid_next;
    sts_out_t                 m_item_reg, m_item_next;

    logic                     s_fire;
    logic signed [BW-1:0]     bound_sum;
    logic signed [BW-1:0]     mid;
    logic                     key_eq;
    logic                     key_lt;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    // Linear mode steps low up from the start index; its midpoint is just low.
    assign bound_sum = low_reg + high_reg;
    assign mid       = binary_reg ? (bound_sum >>> 1) : low_reg;

    // Shared comparator
    assign key_eq = (rd_data == key_reg);
    assign key_lt = (key_reg < rd_data);

    assign wr_en   = s_fire && (s_item.action == ACT_WRITE)
                     && (int'(s_item.entry_index) < DEPTH);
    assign wr_addr = AW'(s_item.entry_index);
    assign wr_data = s_item.entry_value;
    assign rd_en   = (state_reg == S_PROBE) && (low_reg <= high_reg);
    assign rd_addr = AW'(mid);

    always_comb begin
        state_next   = state_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        probe_next   = probe_reg;
        key_next     = key_reg;
        binary_next  = binary_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_item.action == ACT_LINEAR ||
                               s_item.action == ACT_BINARY)) begin
                    low_next    = '0;
                    high_next   = $signed({1'b0, active_count}) - BW'(1);
                    key_next    = s_item.search_key;
                    binary_next = (s_item.action == ACT_BINARY);
                    state_next  = S_PROBE;
                end
            end
            S_PROBE: begin
                if (low_reg > high_reg) begin
                    result_next.found       = 1'b0;
                    result_next.match_index = '0;
                    state_next              = S_DONE;
                end else begin
                    probe_next = mid;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (key_eq) begin
                    result_next.found       = 1'b1;
                    result_next.match_index = IDX_W'(probe_reg);
                    state_next              = S_DONE;
                end else begin
                    if (binary_reg && key_lt) begin
                        high_next = probe_reg - BW'(1);
                    end else begin
                        low_next = probe_reg + BW'(1);
                    end
                    state_next = S_PROBE;
                end
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = result_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg    <= low_next;
        high_reg   <= high_next;
        probe_reg  <= probe_next;
        key_reg    <= key_next;
        binary_reg <= binary_next;
        result_reg <= result_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_item_reg.found |-> m_item_reg.match_index == '0)
        else $error("miss result carries a nonzero index");

    a_check_after_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CHECK |-> $past(state_reg) == S_PROBE)
        else $error("compare without a preceding table read");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> mid >= 0 && int'(mid) < DEPTH && mid <= high_reg)
        else $error("table read outside the active bounds");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CHECK || state_reg == S_DONE |=> !$rose(m_valid_reg) ||
        $past(state_reg) == S_DONE)
        else $error("result presented without finishing a search");

endmodule

### sv/sorted_table_search_unit.sv
// Sorted table search unit: a loaded table searched linearly or by bisection.
// Each compare passes a PROBE state (table read) and a CHECK state; a hit or a miss then
// goes via DONE into the output register. A search makes k compares: linear k <= DEPTH,
// binary k <= log2(DEPTH)+1. One item at a time: the next accept waits until the result
// loads, set by the single read port and comparator; a held result stalls the input.
// Reset (aresetn, synchronous, active low) clears entry_count and control; table undefined.
module sorted_table_search_unit
    import sts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  sts_in_t            s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sts_out_t           m_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

    logic [COUNT_W-1:0]       entry_count_reg;
    logic [CW-1:0]            count_ext;
    logic [CW-1:0]            active_count;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            entry_count_reg <= cfg_data;
        end
    end

    // clamp the count to the table depth
    assign count_ext    = CW'(entry_count_reg);
    assign active_count = (count_ext > CW'(DEPTH)) ? CW'(DEPTH) : count_ext;

    sts_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active_count (active_count),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    sts_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
